[src/ymcr_pkg.sv]
// ----------------------------------------------------------------------------
// ymcr_pkg
// Shared constants and types of the YMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package ymcr_pkg;

   // command codes
   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_BYTE  = 3'd1;
   localparam logic [2:0] CMD_TICK  = 3'd2;
   localparam logic [2:0] CMD_FLASH = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_SEND   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_BUFFER = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   // protocol bytes
   localparam logic [7:0] B_SOH = 8'h01;
   localparam logic [7:0] B_STX = 8'h02;
   localparam logic [7:0] B_EOT = 8'h04;
   localparam logic [7:0] B_ACK = 8'h06;
   localparam logic [7:0] B_NAK = 8'h15;
   localparam logic [7:0] B_CAN = 8'h18;
   localparam logic [7:0] B_C   = 8'h43;

   // session phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_DATA    = 3'd2;
   localparam logic [2:0] PH_EOT2    = 3'd3;
   localparam logic [2:0] PH_CLOSING = 3'd4;
   localparam logic [2:0] PH_FLASH   = 3'd5;

   // packet outcomes
   localparam logic [1:0] OC_NONE = 2'd0;
   localparam logic [1:0] OC_ERR  = 2'd1;
   localparam logic [1:0] OC_EOT  = 2'd2;
   localparam logic [1:0] OC_GOOD = 2'd3;

   // finish status
   localparam logic [1:0] FIN_OK     = 2'd0;
   localparam logic [1:0] FIN_NOFILE = 2'd1;
   localparam logic [1:0] FIN_FAIL   = 2'd2;

   // register indexes
   localparam logic [2:0] REG_BASE  = 3'd0;
   localparam logic [2:0] REG_LIMIT = 3'd1;
   localparam logic [2:0] REG_RETRY = 3'd2;
   localparam logic [2:0] REG_PTO   = 3'd3;
   localparam logic [2:0] REG_BTO   = 3'd4;

   localparam int unsigned SHORT_LEN = 128;
   localparam int unsigned LONG_LEN  = 1024;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   // one result word: kind, tx, addr, len, bdata, status, size
   typedef struct packed {
      logic [31:0] file_size;
      logic [1:0]  finish_status;
      logic [7:0]  buffer_data;
      logic [10:0] write_length;
      logic [31:0] write_address;
      logic [7:0]  tx_data;
      logic [1:0]  kind;
   } result_type;

   // crc-16/xmodem over one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
      end
      return r;
   endfunction

endpackage

[src/ymodem_crc_receiver.sv]
// ----------------------------------------------------------------------------
// ymodem_crc_receiver
// YMODEM-CRC receive engine: packet framing, crc check, payload buffer,
// file size parsing and reply generation.
// ----------------------------------------------------------------------------
// results of an item are written into the result queue at the edge that
// accepts it; a buffer read first passes the registered memory read port.
// throughput: one item per cycle while the result queue has room for three
// words; a buffer read holds off the next item until its word is queued.
// reset: synchronous; session idle, registers at their defaults, the payload
// buffer is not cleared.
module ymodem_crc_receiver #(
   parameter int unsigned PAYLOAD_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] command, [10:3] rx_data, [11] flash_ok, [21:12] buffer_index
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] kind, [9:2] tx_data, [41:10] write_address, [52:42] write_length,
   // [60:53] buffer_data, [62:61] finish_status, [94:63] file_size
   output logic [95:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);

   // configuration registers
   logic [31:0] base_ff, limit_ff;
   logic [7:0]  retry_lim_ff;
   logic [15:0] pto_ff, bto_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0; limit_ff <= 32'd65536; retry_lim_ff <= 8'd10;
         pto_ff <= 16'd3000; bto_ff <= 16'd1000;
      end else if (csr_valid) begin
         unique case (csr_index)
            ymcr_pkg::REG_BASE:  base_ff <= csr_wdata;
            ymcr_pkg::REG_LIMIT: limit_ff <= csr_wdata;
            ymcr_pkg::REG_RETRY: retry_lim_ff <= csr_wdata[7:0];
            ymcr_pkg::REG_PTO:   pto_ff <= csr_wdata[15:0];
            ymcr_pkg::REG_BTO:   bto_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // input fields
   logic [2:0]    cmd;
   logic [7:0]    rxb;
   logic          fok;
   logic [AW-1:0] bidx;
   assign cmd  = req_tdata[2:0];
   assign rxb  = req_tdata[10:3];
   assign fok  = req_tdata[11];
   assign bidx = req_tdata[12 +: AW];

   // result queue, 4 words
   ymcr_pkg::result_type q_data_ff [4];
   logic                 q_last_ff [4];
   logic [1:0]           q_rd_ff, q_wr_ff;
   logic [2:0]           q_cnt_ff;

   // pending buffer read
   logic read_pend_ff;

   logic acc;
   assign req_tready = (q_cnt_ff <= 3'd1) && !read_pend_ff;
   assign acc = req_tvalid && req_tready;

   // session state
   logic [2:0]  phase_ff, phase_in;
   logic [10:0] pos_ff, pos_in;
   logic        long_ff, long_in;
   logic [7:0]  rseq_ff, rseq_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crch_ff, crch_in;
   logic [7:0]  retry_ff, retry_in;
   logic [15:0] tmo_ff, tmo_in;
   logic [7:0]  eseq_ff, eseq_in;
   logic [31:0] wptr_ff, wptr_in;
   logic [31:0] flen_ff, flen_in;
   logic        named_ff, named_in, dig_ff, dig_in, fbz_ff, fbz_in;
   logic [31:0] acc_ff, acc_in;

   // payload memory
   logic [7:0]    mem [PAYLOAD_DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= rxb;
      mem_rd_ff <= mem[bidx];
   end

   // results of the step
   ymcr_pkg::result_type res [3];
   logic [1:0] nres;

   logic [10:0] plen;
   logic [1:0]  oc;
   logic [10:0] idx;
   logic [15:0] lim;
   logic [15:0] tmo_inc;
   logic [31:0] size;
   logic [7:0]  rtry_nx;
   logic        spent;

   assign plen = long_ff ? 11'(ymcr_pkg::LONG_LEN) : 11'(ymcr_pkg::SHORT_LEN);
   assign idx  = pos_ff - 11'd3;
   assign tmo_inc = (tmo_ff != 16'hFFFF) ? tmo_ff + 16'd1 : tmo_ff;
   assign rtry_nx = retry_ff + 8'd1;
   assign spent = rtry_nx >= retry_lim_ff;

   function automatic ymcr_pkg::result_type mk_send(input logic [7:0] b);
      ymcr_pkg::result_type r;
      r = '0; r.kind = ymcr_pkg::KIND_SEND; r.tx_data = b;
      return r;
   endfunction

   function automatic ymcr_pkg::result_type mk_fin(input logic [1:0] st,
                                                   input logic [31:0] sz);
      ymcr_pkg::result_type r;
      r = '0; r.kind = ymcr_pkg::KIND_FINISH; r.finish_status = st;
      r.file_size = (st == ymcr_pkg::FIN_OK) ? sz : 32'd0;
      return r;
   endfunction

   // next-state logic of one step
   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; long_in = long_ff; rseq_in = rseq_ff;
      crc_in = crc_ff; crch_in = crch_ff; retry_in = retry_ff; tmo_in = tmo_ff;
      eseq_in = eseq_ff; wptr_in = wptr_ff; flen_in = flen_ff;
      named_in = named_ff; dig_in = dig_ff; fbz_in = fbz_ff; acc_in = acc_ff;
      res[0] = '0; res[1] = '0; res[2] = '0; nres = 2'd0;
      mem_we = 1'b0; mem_wa = idx[AW-1:0];
      oc = ymcr_pkg::OC_NONE;
      lim = (pos_ff == 11'd0) ? pto_ff : bto_ff;
      size = named_ff ? acc_ff : 32'd0;

      if (acc) begin
         case (cmd)
            ymcr_pkg::CMD_START: begin
               phase_in = ymcr_pkg::PH_HEADER; pos_in = '0; long_in = 1'b0;
               rseq_in = '0; crc_in = '0; crch_in = '0; retry_in = '0; tmo_in = '0;
               eseq_in = 8'd1; wptr_in = base_ff; flen_in = '0; named_in = 1'b0;
               dig_in = 1'b0; acc_in = '0; fbz_in = 1'b0;
               res[0] = mk_send(ymcr_pkg::B_C); nres = 2'd1;
            end
            ymcr_pkg::CMD_BYTE: begin
               if (phase_ff == ymcr_pkg::PH_HEADER || phase_ff == ymcr_pkg::PH_DATA ||
                   phase_ff == ymcr_pkg::PH_CLOSING) begin
                  // packet framing
                  tmo_in = '0;
                  if (pos_ff == 11'd0) begin
                     if (rxb == ymcr_pkg::B_SOH || rxb == ymcr_pkg::B_STX) begin
                        long_in = (rxb == ymcr_pkg::B_STX); crc_in = '0;
                        named_in = 1'b0; dig_in = 1'b0; acc_in = '0; fbz_in = 1'b0;
                        pos_in = 11'd1;
                     end else if (rxb == ymcr_pkg::B_EOT) oc = ymcr_pkg::OC_EOT;
                     else oc = ymcr_pkg::OC_ERR;
                  end else if (pos_ff == 11'd1) begin
                     rseq_in = rxb; pos_in = 11'd2;
                  end else if (pos_ff == 11'd2) begin
                     if ((rseq_ff ^ rxb) != 8'hFF) begin
                        pos_in = '0; oc = ymcr_pkg::OC_ERR;
                     end else pos_in = 11'd3;
                  end else if (idx < plen) begin
                     mem_we = 1'b1;
                     crc_in = ymcr_pkg::crc_byte(crc_ff, rxb);
                     if (idx < 11'(ymcr_pkg::SHORT_LEN)) begin
                        if (idx == 11'd0) fbz_in = (rxb == 8'd0);
                        if (!named_ff) begin
                           if (rxb == 8'd0) begin named_in = 1'b1; dig_in = 1'b1; end
                        end else if (dig_ff) begin
                           if (rxb >= 8'h30 && rxb <= 8'h39)
                              acc_in = (acc_ff << 3) + (acc_ff << 1) + {24'd0, rxb - 8'h30};
                           else dig_in = 1'b0;
                        end
                     end
                     pos_in = pos_ff + 11'd1;
                  end else if (idx == plen) begin
                     crch_in = rxb; pos_in = pos_ff + 11'd1;
                  end else begin
                     pos_in = '0;
                     oc = ({crch_ff, rxb} == crc_ff) ? ymcr_pkg::OC_GOOD : ymcr_pkg::OC_ERR;
                  end
               end else if (phase_ff == ymcr_pkg::PH_EOT2) begin
                  tmo_in = '0;
                  if (rxb == ymcr_pkg::B_EOT) begin
                     res[0] = mk_send(ymcr_pkg::B_ACK); res[1] = mk_send(ymcr_pkg::B_C);
                     nres = 2'd2; phase_in = ymcr_pkg::PH_CLOSING; retry_in = '0;
                     pos_in = '0;
                  end else begin
                     res[0] = mk_fin(ymcr_pkg::FIN_FAIL, flen_ff); nres = 2'd1;
                     phase_in = ymcr_pkg::PH_IDLE; pos_in = '0; tmo_in = '0;
                  end
               end
            end
            ymcr_pkg::CMD_TICK: begin
               if (phase_ff == ymcr_pkg::PH_HEADER || phase_ff == ymcr_pkg::PH_DATA ||
                   phase_ff == ymcr_pkg::PH_CLOSING) begin
                  tmo_in = tmo_inc;
                  if (tmo_inc >= lim) begin
                     pos_in = '0; oc = ymcr_pkg::OC_ERR;
                  end
               end else if (phase_ff == ymcr_pkg::PH_EOT2) begin
                  tmo_in = tmo_inc;
                  if (tmo_inc >= pto_ff) begin
                     res[0] = mk_fin(ymcr_pkg::FIN_FAIL, flen_ff); nres = 2'd1;
                     phase_in = ymcr_pkg::PH_IDLE; pos_in = '0; tmo_in = '0;
                  end
               end
            end
            ymcr_pkg::CMD_FLASH: begin
               if (phase_ff == ymcr_pkg::PH_FLASH) begin
                  if (fok) begin
                     wptr_in = wptr_ff + {21'd0, plen};
                     res[0] = mk_send(ymcr_pkg::B_ACK); nres = 2'd1;
                     eseq_in = eseq_ff + 8'd1; phase_in = ymcr_pkg::PH_DATA;
                     retry_in = '0; tmo_in = '0; pos_in = '0;
                  end else begin
                     res[0] = mk_send(ymcr_pkg::B_CAN); res[1] = mk_send(ymcr_pkg::B_CAN);
                     res[2] = mk_fin(ymcr_pkg::FIN_FAIL, flen_ff); nres = 2'd3;
                     phase_in = ymcr_pkg::PH_IDLE; pos_in = '0; tmo_in = '0;
                  end
               end
            end
            default: ;
         endcase

         // packet outcome
         if (oc != ymcr_pkg::OC_NONE) begin
            tmo_in = '0;
            if (phase_ff == ymcr_pkg::PH_HEADER) begin
               if (oc == ymcr_pkg::OC_GOOD && rseq_ff == 8'd0) begin
                  if (fbz_ff) begin
                     res[0] = mk_send(ymcr_pkg::B_ACK);
                     res[1] = mk_fin(ymcr_pkg::FIN_NOFILE, flen_ff); nres = 2'd2;
                     phase_in = ymcr_pkg::PH_IDLE;
                  end else if (size == 32'd0 || size > limit_ff) begin
                     res[0] = mk_send(ymcr_pkg::B_CAN); res[1] = mk_send(ymcr_pkg::B_CAN);
                     res[2] = mk_fin(ymcr_pkg::FIN_FAIL, flen_ff); nres = 2'd3;
                     phase_in = ymcr_pkg::PH_IDLE;
                  end else begin
                     flen_in = size;
                     res[0] = mk_send(ymcr_pkg::B_ACK); res[1] = mk_send(ymcr_pkg::B_C);
                     nres = 2'd2; phase_in = ymcr_pkg::PH_DATA; eseq_in = 8'd1;
                     retry_in = '0;
                  end
               end else begin
                  retry_in = rtry_nx;
                  if (oc == ymcr_pkg::OC_EOT) begin
                     res[0] = mk_send(ymcr_pkg::B_ACK);
                     res[1] = spent ? mk_fin(ymcr_pkg::FIN_FAIL, flen_ff)
                                    : mk_send(ymcr_pkg::B_C);
                     nres = 2'd2;
                  end else begin
                     res[0] = spent ? mk_fin(ymcr_pkg::FIN_FAIL, flen_ff)
                                    : mk_send(ymcr_pkg::B_C);
                     nres = 2'd1;
                  end
                  if (spent) phase_in = ymcr_pkg::PH_IDLE;
               end
            end else if (phase_ff == ymcr_pkg::PH_DATA) begin
               if (oc == ymcr_pkg::OC_ERR) begin
                  res[0] = mk_send(ymcr_pkg::B_NAK); nres = 2'd1; retry_in = rtry_nx;
                  if (spent) begin
                     res[1] = mk_fin(ymcr_pkg::FIN_FAIL, flen_ff); nres = 2'd2;
                     phase_in = ymcr_pkg::PH_IDLE;
                  end
               end else begin
                  retry_in = '0;
                  if (oc == ymcr_pkg::OC_EOT) begin
                     res[0] = mk_send(ymcr_pkg::B_NAK); nres = 2'd1;
                     phase_in = ymcr_pkg::PH_EOT2;
                  end else if (rseq_ff != eseq_ff) begin
                     res[0] = mk_send((rseq_ff == eseq_ff - 8'd1) ? ymcr_pkg::B_ACK
                                                                  : ymcr_pkg::B_NAK);
                     nres = 2'd1;
                  end else begin
                     res[0] = '0; res[0].kind = ymcr_pkg::KIND_WRITE;
                     res[0].write_address = wptr_ff; res[0].write_length = plen;
                     nres = 2'd1; phase_in = ymcr_pkg::PH_FLASH;
                  end
               end
            end else if (phase_ff == ymcr_pkg::PH_CLOSING) begin
               if (!(oc == ymcr_pkg::OC_GOOD && rseq_ff == 8'd0)) retry_in = rtry_nx;
               if ((oc == ymcr_pkg::OC_GOOD && rseq_ff == 8'd0) || spent) begin
                  res[0] = mk_send(ymcr_pkg::B_ACK);
                  res[1] = mk_fin(ymcr_pkg::FIN_OK, flen_ff); nres = 2'd2;
                  phase_in = ymcr_pkg::PH_IDLE;
               end
            end
            if (phase_in == ymcr_pkg::PH_IDLE) begin
               pos_in = '0;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ymcr_pkg::PH_IDLE; pos_ff <= '0; long_ff <= 1'b0; rseq_ff <= '0;
         crc_ff <= '0; crch_ff <= '0; retry_ff <= '0; tmo_ff <= '0; eseq_ff <= 8'd1;
         wptr_ff <= '0; flen_ff <= '0; named_ff <= 1'b0; dig_ff <= 1'b0;
         fbz_ff <= 1'b0; acc_ff <= '0;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; long_ff <= long_in; rseq_ff <= rseq_in;
         crc_ff <= crc_in; crch_ff <= crch_in; retry_ff <= retry_in; tmo_ff <= tmo_in;
         eseq_ff <= eseq_in; wptr_ff <= wptr_in; flen_ff <= flen_in;
         named_ff <= named_in; dig_ff <= dig_in; fbz_ff <= fbz_in; acc_ff <= acc_in;
      end
   end

   // result queue push and pop
   logic       pop;
   logic [1:0] npush;
   ymcr_pkg::result_type rd_word;
   assign pop = rsp_tvalid && rsp_tready;
   assign npush = read_pend_ff ? 2'd1 : nres;

   always_comb begin
      rd_word = '0;
      rd_word.kind = ymcr_pkg::KIND_BUFFER;
      rd_word.buffer_data = mem_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_rd_ff <= '0; q_wr_ff <= '0; q_cnt_ff <= '0; read_pend_ff <= 1'b0;
      end else begin
         read_pend_ff <= acc && (cmd == ymcr_pkg::CMD_READ);
         if (read_pend_ff) begin
            q_data_ff[q_wr_ff] <= rd_word;
            q_last_ff[q_wr_ff] <= 1'b1;
         end else begin
            for (int k = 0; k < 3; k++) begin
               if (2'(k) < nres) begin
                  q_data_ff[q_wr_ff + 2'(k)] <= res[k];
                  q_last_ff[q_wr_ff + 2'(k)] <= (2'(k) == nres - 2'd1);
               end
            end
         end
         q_wr_ff <= q_wr_ff + npush;
         q_rd_ff <= q_rd_ff + {1'b0, pop};
         q_cnt_ff <= q_cnt_ff + {1'b0, npush} - {2'b0, pop};
      end
   end

   assign rsp_tvalid = (q_cnt_ff != 3'd0);
   assign rsp_tdata  = {1'b0, q_data_ff[q_rd_ff]};
   assign rsp_tlast  = q_last_ff[q_rd_ff];

   // checks
   a_qcnt: assert property (@(posedge clock) disable iff (reset) q_cnt_ff <= 3'd4)
      else $error("result queue overflow");
   a_nopend: assert property (@(posedge clock) disable iff (reset)
      read_pend_ff |-> !acc) else $error("item taken during buffer read");
   a_idlepos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == ymcr_pkg::PH_IDLE |-> pos_ff == 11'd0)
      else $error("packet position left open while idle");

endmodule

[tb/ymcr_checker.sv]
// ----------------------------------------------------------------------------
// ymcr_checker
// Watches the request, response and register channels of the YMODEM-CRC
// receiver. Keeps its own copy of the session state, works out the reply
// words each accepted request word should cause, and compares every response
// word field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module ymcr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          errors,
   output int          pending,
   output int          matched
);
   timeunit 1ns;
   timeprecision 1ps;
   import ymcr_pkg::*;

   typedef struct {
      result_type word;
      bit         last;
   } reply_t;

   reply_t replies_due[$];
   reply_t step_replies[$];

   // register copies
   logic [31:0] base_addr;
   logic [31:0] size_limit;
   logic [7:0]  retry_max;
   logic [15:0] hdr_timeout;
   logic [15:0] gap_timeout;

   // session state
   logic [2:0]  phase;
   logic [10:0] pkt_pos;
   logic        long_pkt;
   logic [7:0]  rx_seq;
   logic [15:0] crc_run;
   logic [7:0]  crc_hi;
   logic [7:0]  retries;
   logic [15:0] tick_cnt;
   logic [7:0]  next_seq;
   logic [31:0] flash_ptr;
   logic [31:0] file_len;
   logic        name_seen;
   logic        digits_open;
   logic [31:0] size_acc;
   logic        first_zero;
   logic [7:0]  payload [1024];

   initial begin
      errors = 0;
      pending = 0;
      matched = 0;
   end

   function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (r[15]) r = {r[14:0], 1'b0} ^ 16'h1021;
         else r = {r[14:0], 1'b0};
      end
      return r;
   endfunction

   function automatic void push_reply(input logic [1:0] k, input logic [7:0] tx,
                                      input logic [31:0] adr, input logic [10:0] len,
                                      input logic [7:0] bd, input logic [1:0] st,
                                      input logic [31:0] sz);
      reply_t r;
      if (step_replies.size() >= 3) return;
      r.word.kind = k;
      r.word.tx_data = tx;
      r.word.write_address = adr;
      r.word.write_length = len;
      r.word.buffer_data = bd;
      r.word.finish_status = st;
      r.word.file_size = sz;
      r.last = 1'b0;
      step_replies.push_back(r);
   endfunction

   function automatic void reply_byte(input logic [7:0] b);
      push_reply(KIND_SEND, b, 32'd0, 11'd0, 8'd0, FIN_OK, 32'd0);
   endfunction

   function automatic void end_session(input logic [1:0] st);
      push_reply(KIND_FINISH, 8'd0, 32'd0, 11'd0, 8'd0, st, st == FIN_OK ? file_len : 32'd0);
      phase = PH_IDLE;
      pkt_pos = 0;
      tick_cnt = 0;
   endfunction

   function automatic int unsigned body_len();
      return long_pkt ? LONG_LEN : SHORT_LEN;
   endfunction

   function automatic logic retry_spent();
      retries = retries + 8'd1;
      return retries >= retry_max;
   endfunction

   // frame one received byte, returns the packet outcome
   function automatic logic [1:0] frame_byte(input logic [7:0] b);
      int unsigned pos, len, i;
      pos = pkt_pos;
      len = body_len();
      tick_cnt = 0;
      if (pos == 0) begin
         if (b == B_SOH || b == B_STX) begin
            long_pkt = (b == B_STX);
            crc_run = 0;
            name_seen = 0;
            digits_open = 0;
            size_acc = 0;
            first_zero = 0;
            pkt_pos = 1;
            return OC_NONE;
         end
         return (b == B_EOT) ? OC_EOT : OC_ERR;
      end
      if (pos == 1) begin
         rx_seq = b;
         pkt_pos = 2;
         return OC_NONE;
      end
      if (pos == 2) begin
         if ((rx_seq ^ b) != 8'hFF) begin
            pkt_pos = 0;
            return OC_ERR;
         end
         pkt_pos = 3;
         return OC_NONE;
      end
      if (pos < 3 + len) begin
         i = pos - 3;
         payload[i] = b;
         crc_run = crc_next(crc_run, b);
         // name then decimal size, only in the first 128 bytes
         if (i < SHORT_LEN) begin
            if (i == 0) first_zero = (b == 8'h00);
            if (!name_seen) begin
               if (b == 8'h00) begin
                  name_seen = 1;
                  digits_open = 1;
               end
            end else if (digits_open) begin
               if (b >= 8'h30 && b <= 8'h39) size_acc = size_acc * 32'd10 + 32'(b - 8'h30);
               else digits_open = 0;
            end
         end
         pkt_pos = 11'(pos + 1);
         return OC_NONE;
      end
      if (pos == 3 + len) begin
         crc_hi = b;
         pkt_pos = 11'(pos + 1);
         return OC_NONE;
      end
      pkt_pos = 0;
      if (pos == 4 + len && {crc_hi, b} == crc_run) return OC_GOOD;
      return OC_ERR;
   endfunction

   function automatic void header_done(input logic [1:0] oc);
      logic [31:0] sz;
      if (oc == OC_GOOD && rx_seq == 8'd0) begin
         sz = name_seen ? size_acc : 32'd0;
         if (first_zero) begin
            reply_byte(B_ACK);
            end_session(FIN_NOFILE);
            return;
         end
         if (sz == 0 || sz > size_limit) begin
            reply_byte(B_CAN);
            reply_byte(B_CAN);
            end_session(FIN_FAIL);
            return;
         end
         file_len = sz;
         reply_byte(B_ACK);
         reply_byte(B_C);
         phase = PH_DATA;
         next_seq = 1;
         retries = 0;
         return;
      end
      if (oc == OC_EOT) reply_byte(B_ACK);
      if (retry_spent()) end_session(FIN_FAIL);
      else reply_byte(B_C);
   endfunction

   function automatic void data_done(input logic [1:0] oc);
      if (oc == OC_ERR) begin
         reply_byte(B_NAK);
         if (retry_spent()) end_session(FIN_FAIL);
         return;
      end
      retries = 0;
      if (oc == OC_EOT) begin
         reply_byte(B_NAK);
         phase = PH_EOT2;
         return;
      end
      if (rx_seq != next_seq) begin
         // repeat of the previous block is acknowledged again
         reply_byte(rx_seq == next_seq - 8'd1 ? B_ACK : B_NAK);
         return;
      end
      push_reply(KIND_WRITE, 8'd0, flash_ptr, 11'(body_len()), 8'd0, FIN_OK, 32'd0);
      phase = PH_FLASH;
   endfunction

   function automatic void packet_done(input logic [1:0] oc);
      if (oc == OC_NONE) return;
      tick_cnt = 0;
      case (phase)
         PH_HEADER: header_done(oc);
         PH_DATA: data_done(oc);
         PH_CLOSING: begin
            if ((oc == OC_GOOD && rx_seq == 8'd0) || retry_spent()) begin
               reply_byte(B_ACK);
               end_session(FIN_OK);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void reset_session();
      pkt_pos = 0;
      long_pkt = 0;
      rx_seq = 0;
      crc_run = 0;
      crc_hi = 0;
      retries = 0;
      tick_cnt = 0;
      next_seq = 1;
      file_len = 0;
      name_seen = 0;
      digits_open = 0;
      size_acc = 0;
      first_zero = 0;
   endfunction

   // expected reply words for one request word
   function automatic void predict(input logic [2:0] cmd, input logic [7:0] b,
                                   input logic ok, input logic [9:0] idx);
      logic [15:0] lim;
      step_replies.delete();
      case (cmd)
         CMD_START: begin
            reset_session();
            phase = PH_HEADER;
            flash_ptr = base_addr;
            reply_byte(B_C);
         end
         CMD_BYTE: begin
            if (phase == PH_HEADER || phase == PH_DATA || phase == PH_CLOSING) begin
               packet_done(frame_byte(b));
            end else if (phase == PH_EOT2) begin
               tick_cnt = 0;
               if (b == B_EOT) begin
                  reply_byte(B_ACK);
                  reply_byte(B_C);
                  phase = PH_CLOSING;
                  retries = 0;
                  pkt_pos = 0;
               end else begin
                  end_session(FIN_FAIL);
               end
            end
         end
         CMD_TICK: begin
            if (phase == PH_HEADER || phase == PH_DATA || phase == PH_CLOSING) begin
               lim = (pkt_pos == 0) ? hdr_timeout : gap_timeout;
               if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
               if (tick_cnt >= lim) begin
                  pkt_pos = 0;
                  packet_done(OC_ERR);
               end
            end else if (phase == PH_EOT2) begin
               if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
               if (tick_cnt >= hdr_timeout) end_session(FIN_FAIL);
            end
         end
         CMD_FLASH: begin
            if (phase == PH_FLASH) begin
               if (ok) begin
                  flash_ptr = flash_ptr + body_len();
                  reply_byte(B_ACK);
                  next_seq = next_seq + 8'd1;
                  phase = PH_DATA;
                  retries = 0;
                  tick_cnt = 0;
                  pkt_pos = 0;
               end else begin
                  reply_byte(B_CAN);
                  reply_byte(B_CAN);
                  end_session(FIN_FAIL);
               end
            end
         end
         CMD_READ: push_reply(KIND_BUFFER, 8'd0, 32'd0, 11'd0, payload[idx], FIN_OK, 32'd0);
         default: ;
      endcase
      if (step_replies.size() > 0) step_replies[step_replies.size() - 1].last = 1'b1;
      foreach (step_replies[n]) replies_due.push_back(step_replies[n]);
   endfunction

   always @(posedge clock) begin : watch
      reply_t want;
      result_type got;
      if (reset) begin
         base_addr = 0;
         size_limit = 32'd65536;
         retry_max = 8'd10;
         hdr_timeout = 16'd3000;
         gap_timeout = 16'd1000;
         phase = PH_IDLE;
         reset_session();
         flash_ptr = 0;
         replies_due.delete();
      end else begin
         // response word against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[94:0]);
            if (replies_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%t: unexpected word kind=%0d tdata=%h last=%0d",
                           $realtime, got.kind, rsp_tdata, rsp_tlast);
            end else begin
               want = replies_due.pop_front();
               if (got.kind !== want.word.kind || got.tx_data !== want.word.tx_data ||
                   got.write_address !== want.word.write_address ||
                   got.write_length !== want.word.write_length ||
                   got.buffer_data !== want.word.buffer_data ||
                   got.finish_status !== want.word.finish_status ||
                   got.file_size !== want.word.file_size || rsp_tlast !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%t: mismatch exp kind=%0d tx=%h adr=%h len=%0d bd=%h st=%0d ",
                               "size=%0d last=%0d / got kind=%0d tx=%h adr=%h len=%0d bd=%h ",
                               "st=%0d size=%0d last=%0d"}, $realtime,
                              want.word.kind, want.word.tx_data, want.word.write_address,
                              want.word.write_length, want.word.buffer_data,
                              want.word.finish_status, want.word.file_size, want.last,
                              got.kind, got.tx_data, got.write_address, got.write_length,
                              got.buffer_data, got.finish_status, got.file_size, rsp_tlast);
               end else begin
                  matched++;
               end
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BASE: base_addr = csr_wdata;
               REG_LIMIT: size_limit = csr_wdata;
               REG_RETRY: retry_max = csr_wdata[7:0];
               REG_PTO: hdr_timeout = csr_wdata[15:0];
               REG_BTO: gap_timeout = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict(req_tdata[2:0], req_tdata[10:3], req_tdata[11], req_tdata[21:12]);
      end
      pending = replies_due.size();
   end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives YMODEM-CRC sessions into the receiver: directed corner sessions
// (timeouts, bad framing, empty and oversized headers, flash failures, lost
// closing packet), then random sessions with random payloads, retransmits and
// noise under several register settings. Checking is done by ymcr_checker.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ymcr_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int FLAW_NONE = 0;
   localparam int FLAW_CRC = 1;
   localparam int FLAW_COMPL = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   int          errors, pending, matched;
   int          cycles = 0;
   int          burst_left = 0;
   int          sent = 0;
   int          sessions = 0;
   int unsigned safe_len = 0;
   logic [31:0] limit_now = 32'd65536;
   logic [7:0]  pay [1024];
   logic        hold_req = 1'b0;
   logic        hold_taken = 1'b0;
   int          hold_left = 0;
   logic [11:0] pattern_step = '0;

   ymodem_crc_receiver i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   ymcr_checker i_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending), .matched(matched)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // receiver: one long hold on request, otherwise rotating stall patterns
   always @(posedge clock) begin
      pattern_step <= pattern_step + 12'd1;
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_left <= 160;
         hold_taken <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         case (pattern_step[11:9])
            3'd0, 3'd4: rsp_tready <= 1'b1;
            3'd1, 3'd5: rsp_tready <= pattern_step[2:0] != 3'd3 && pattern_step[2:0] != 3'd6;
            3'd2: rsp_tready <= pattern_step[0];
            default: rsp_tready <= $urandom_range(0, 3) != 0;
         endcase
      end
   end

   function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
      return r;
   endfunction

   // one request word, sent in bursts with random gaps
   task automatic put_item(input logic [2:0] cmd, input logic [7:0] b, input logic ok,
                           input logic [9:0] idx);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, idx, ok, b, cmd};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic byte_in(input logic [7:0] b);
      put_item(CMD_BYTE, b, 1'b0, 10'd0);
   endtask

   task automatic ticks(input int n);
      repeat (n) put_item(CMD_TICK, 8'($urandom), 1'b0, 10'd0);
   endtask

   task automatic start_session();
      put_item(CMD_START, 8'd0, 1'b0, 10'd0);
      sessions++;
   endtask

   task automatic read_back(input logic [9:0] idx);
      put_item(CMD_READ, 8'd0, 1'b0, idx);
   endtask

   // sender pause until every expected word has come
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_LIMIT) limit_now = val;
   endtask

   task automatic set_regs(input logic [31:0] base, input logic [31:0] lim,
                           input logic [7:0] rty, input logic [15:0] pto,
                           input logic [15:0] bto);
      write_reg(REG_BASE, base);
      write_reg(REG_LIMIT, lim);
      write_reg(REG_RETRY, {24'd0, rty});
      write_reg(REG_PTO, {16'd0, pto});
      write_reg(REG_BTO, {16'd0, bto});
   endtask

   // packet framing: header byte, block number, complement, body, crc
   task automatic send_packet(input logic lng, input logic [7:0] blk, input int flaw);
      int unsigned len;
      logic [15:0] c;
      len = lng ? LONG_LEN : SHORT_LEN;
      c = 16'd0;
      byte_in(lng ? B_STX : B_SOH);
      byte_in(blk);
      if (flaw == FLAW_COMPL) begin
         byte_in(blk);
         return;
      end
      byte_in(~blk);
      for (int i = 0; i < len; i++) begin
         byte_in(pay[i]);
         c = crc_step(c, pay[i]);
      end
      if (len > safe_len) safe_len = len;
      if (flaw == FLAW_CRC) c = ~c;
      byte_in(c[15:8]);
      byte_in(c[7:0]);
   endtask

   // header body: name, zero, decimal size, then some trailing text
   task automatic fill_header(input logic [31:0] sz);
      string name, digits;
      int p;
      foreach (pay[i]) pay[i] = 8'h00;
      name = $sformatf("f%0d.bin", $urandom_range(0, 999));
      digits = $sformatf("%0d", sz);
      for (int i = 0; i < name.len(); i++) pay[i] = name[i];
      p = name.len() + 1;
      for (int i = 0; i < digits.len(); i++) pay[p + i] = digits[i];
      p = p + digits.len();
      pay[p] = 8'h20;
      pay[p + 1] = 8'h37;
   endtask

   task automatic fill_random();
      foreach (pay[i]) pay[i] = 8'($urandom);
   endtask

   task automatic fill_const(input logic [7:0] v);
      foreach (pay[i]) pay[i] = v;
   endtask

   // well-formed session with random flaws sprinkled in
   task automatic session(input int blocks, input logic lng_data, input logic flaky);
      logic [31:0] sz;
      sz = (limit_now > 32'd1 && limit_now < 32'd60000) ? $urandom_range(1, limit_now)
                                                         : $urandom_range(1, 60000);
      start_session();
      fill_header(sz);
      send_packet(1'b0, 8'd0, FLAW_NONE);
      for (int blk = 1; blk <= blocks; blk++) begin
         fill_random();
         if (flaky && $urandom_range(0, 2) == 0)
            send_packet(lng_data, 8'(blk), $urandom_range(0, 1) ? FLAW_CRC : FLAW_COMPL);
         if (flaky && $urandom_range(0, 2) == 0) ticks($urandom_range(1, 3));
         send_packet(lng_data, 8'(blk), FLAW_NONE);
         if ($urandom_range(0, 2) == 0) byte_in(8'($urandom));
         put_item(CMD_FLASH, 8'd0, !(flaky && $urandom_range(0, 7) == 0), 10'd0);
         if (flaky && $urandom_range(0, 3) == 0) send_packet(lng_data, 8'(blk), FLAW_NONE);
         read_back(10'($urandom_range(0, safe_len - 1)));
      end
      byte_in(B_EOT);
      byte_in(B_EOT);
      fill_const(8'h00);
      send_packet(1'b0, 8'd0, FLAW_NONE);
   endtask

   // random words of every command, mostly into a live session
   task automatic noise(input int n);
      int pick;
      start_session();
      repeat (n) begin
         pick = $urandom_range(0, 15);
         case (pick)
            0: put_item(CMD_START, 8'($urandom), 1'($urandom), 10'($urandom));
            1, 2: ticks(1);
            3: put_item(CMD_FLASH, 8'($urandom), 1'($urandom), 10'($urandom));
            4: read_back(10'($urandom_range(0, safe_len - 1)));
            5: put_item(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom), 10'($urandom));
            6: byte_in(B_EOT);
            7: byte_in(($urandom_range(0, 1) != 0) ? B_SOH : B_STX);
            default: byte_in(8'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all registers, short limits so corners are quick
      set_regs(32'h0800_0000, 32'd65536, 8'd3, 16'd5, 16'd4);

      // ignored words while idle
      put_item(3'd5, 8'hFF, 1'b1, 10'h3FF);
      put_item(3'd6, 8'h00, 1'b0, 10'h000);
      put_item(3'd7, 8'hA5, 1'b1, 10'h155);
      byte_in(B_SOH);
      ticks(1);
      put_item(CMD_FLASH, 8'd0, 1'b1, 10'd0);

      // header timeout, bad header byte, long header, wrong block, bad complement
      start_session();
      ticks(5);
      byte_in(B_CAN);
      fill_header(32'd300);
      for (int i = 200; i < LONG_LEN; i++) pay[i] = 8'($urandom);
      send_packet(1'b1, 8'd0, FLAW_NONE);
      read_back(10'd0);
      read_back(10'd1023);
      read_back(10'd512);
      fill_random();
      send_packet(1'b0, 8'd5, FLAW_NONE);
      send_packet(1'b0, 8'd1, FLAW_COMPL);
      send_packet(1'b0, 8'd1, FLAW_NONE);
      byte_in(8'hFF);
      ticks(1);
      put_item(CMD_FLASH, 8'd0, 1'b1, 10'd0);
      send_packet(1'b0, 8'd1, FLAW_NONE);
      send_packet(1'b0, 8'd2, FLAW_NONE);
      put_item(CMD_FLASH, 8'd0, 1'b0, 10'd0);

      // EOT in the header phase, then retries run out
      start_session();
      byte_in(B_EOT);
      byte_in(B_CAN);
      byte_in(B_CAN);

      // empty name: no file
      start_session();
      fill_const(8'h00);
      send_packet(1'b0, 8'd0, FLAW_NONE);

      // no name terminator: size zero, cancelled
      start_session();
      fill_const(8'h78);
      send_packet(1'b0, 8'd0, FLAW_NONE);

      // size above the limit
      start_session();
      fill_header(32'd70000);
      send_packet(1'b0, 8'd0, FLAW_NONE);

      // byte timeout, then a second EOT that is not an EOT
      start_session();
      fill_header(32'd128);
      send_packet(1'b0, 8'd0, FLAW_NONE);
      byte_in(B_SOH);
      ticks(4);
      fill_random();
      send_packet(1'b0, 8'd1, FLAW_NONE);
      put_item(CMD_FLASH, 8'd0, 1'b1, 10'd0);
      byte_in(B_EOT);
      byte_in(8'h55);

      // closing packet never comes
      start_session();
      fill_header(32'd9);
      send_packet(1'b0, 8'd0, FLAW_NONE);
      byte_in(B_EOT);
      byte_in(B_EOT);
      ticks(15);

      // size far above the limit, then a second EOT that never comes
      start_session();
      fill_header(32'd4000000000);
      send_packet(1'b0, 8'd0, FLAW_NONE);
      start_session();
      fill_header(32'd77);
      send_packet(1'b0, 8'd0, FLAW_NONE);
      byte_in(B_EOT);
      ticks(5);

      // receiver holds off while header noise fills the block
      set_regs(32'hFFFF_FF80, 32'hFFFF_FFFF, 8'd255, 16'd65535, 16'd65535);
      start_session();
      hold_req <= 1'b1;
      repeat (40) byte_in(8'h55);
      drain();

      // random sessions across register settings
      for (int r = 0; r < 6; r++) begin
         case (r % 3)
            0: set_regs($urandom, 32'hFFFF_FFFF, 8'd255, 16'd65535, 16'd65535);
            1: set_regs(32'hFFFF_FF80, 32'd65536, 8'($urandom_range(2, 8)),
                        16'($urandom_range(20, 200)), 16'($urandom_range(20, 200)));
            default: set_regs(32'd0, $urandom_range(1, 3000), 8'd1, 16'd1, 16'd1);
         endcase
         session($urandom_range(1, 3), r == 1, r % 3 != 2);
         noise(30);
         session(1, 1'b0, 1'b0);
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d request words in %0d sessions, %0d response words matched",
               sent, sessions, matched);
      if (errors == 0 && pending == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
